>>> rtl/csw_pkg.sv
// ----------------------------------------------------------------------------
// csw_pkg
// shared types and constants of the category split walker
// ----------------------------------------------------------------------------
package csw_pkg;

    localparam int CFG_W  = 6;
    localparam int KEY_W  = 32;
    localparam int IDX_W  = 1;

    // register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_NUM_CATEGORIES = 1'b0;
    localparam logic [IDX_W-1:0] REG_ORDERED_MODE   = 1'b1;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    // group marks of a category
    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_RIGHT = 2'd1;
    localparam logic [1:0] MARK_LEFT  = 2'd2;

    typedef struct packed {
        logic                    operation;
        logic                    new_set;
        logic                    has_members;
        logic signed [KEY_W-1:0] sort_key;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0] category_index;
        logic             done_res;
    } result_t;

    // result handed from the sequencer to the output register
    typedef struct packed {
        logic    valid;
        result_t data;
    } res_req_t;

endpackage

>>> rtl/csw_ram.sv
// ----------------------------------------------------------------------------
// csw_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module csw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/csw_seq.sv
// ----------------------------------------------------------------------------
// csw_seq
// sequencer: insertion sort on load, gray code or ordered walk on request
// ----------------------------------------------------------------------------
module csw_seq
    import csw_pkg::*;
#(
    parameter int MAX_CATEGORIES = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  item_t                             item,
    input  logic [CFG_W-1:0]                  num_categories,
    input  logic                              ordered_mode,
    input  logic                              res_free,
    output logic                              busy,
    output res_req_t                          res,
    // sorted table ram
    output logic                              cell_we,
    output logic [$clog2(MAX_CATEGORIES)-1:0] cell_waddr,
    output logic [$clog2(MAX_CATEGORIES)+KEY_W-1:0] cell_wdata,
    output logic [$clog2(MAX_CATEGORIES)-1:0] cell_raddr,
    input  logic [$clog2(MAX_CATEGORIES)+KEY_W-1:0] cell_rdata,
    // mark ram
    output logic                              mark_we,
    output logic [$clog2(MAX_CATEGORIES)-1:0] mark_waddr,
    output logic [1:0]                        mark_wdata,
    output logic [$clog2(MAX_CATEGORIES)-1:0] mark_raddr,
    input  logic [1:0]                        mark_rdata
);

    localparam int AW = $clog2(MAX_CATEGORIES);
    localparam int CW = $clog2(MAX_CATEGORIES + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_ORD,
        S_GRAY,
        S_RES
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           loaded_reg, loaded_next;
    logic [CW-1:0]           empty_reg, empty_next;
    logic [CW-1:0]           walk_reg, walk_next;
    logic [AW-1:0]           j_reg, j_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic                    members_reg, members_next;
    result_t                 res_reg, res_next;

    logic [LW-1:0]           lim;
    logic [LW-1:0]           num_ext;
    logic [CW-1:0]           eff_loaded;
    logic [CW-1:0]           eff_empty;
    logic signed [KEY_W-1:0] rd_key;
    logic [AW-1:0]           rd_cat;
    result_t                 done_word;

    assign num_ext = LW'(num_categories);
    assign lim     = (num_ext > LW'(MAX_CATEGORIES)) ? LW'(MAX_CATEGORIES) : num_ext;
    assign rd_key  = signed'(cell_rdata[KEY_W-1:0]);
    assign rd_cat  = cell_rdata[AW+KEY_W-1:KEY_W];

    assign eff_loaded = item.new_set ? '0 : loaded_reg;
    assign eff_empty  = item.new_set ? '0 : empty_reg;

    assign done_word.category_index = num_categories;
    assign done_word.done_res       = 1'b1;

    assign busy      = (state_reg != S_IDLE);
    assign res.valid = (state_reg == S_RES);
    assign res.data  = res_reg;

    always_comb
    begin
        state_next   = state_reg;
        loaded_next  = loaded_reg;
        empty_next   = empty_reg;
        walk_next    = walk_reg;
        j_next       = j_reg;
        pos_next     = pos_reg;
        key_next     = key_reg;
        members_next = members_reg;
        res_next     = res_reg;

        cell_we    = 1'b0;
        cell_waddr = j_reg;
        cell_wdata = {pos_reg, key_reg};
        cell_raddr = j_reg - AW'(1) - AW'(1);
        mark_we    = 1'b0;
        mark_waddr = j_reg;
        mark_wdata = MARK_LEFT;
        mark_raddr = j_reg + AW'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (item.operation == OP_LOAD)
                    begin
                        loaded_next = eff_loaded;
                        empty_next  = eff_empty;
                        if (item.new_set)
                        begin
                            walk_next = '0;
                        end
                        // a full table ignores the load
                        if (eff_loaded < CW'(MAX_CATEGORIES))
                        begin
                            mark_we      = 1'b1;
                            mark_waddr   = eff_loaded[AW-1:0];
                            mark_wdata   = item.has_members ? MARK_RIGHT : MARK_EMPTY;
                            pos_next     = eff_loaded[AW-1:0];
                            j_next       = eff_loaded[AW-1:0];
                            key_next     = item.sort_key;
                            members_next = item.has_members;
                            cell_raddr   = eff_loaded[AW-1:0] - AW'(1);
                            state_next   = S_INS;
                        end
                    end
                    else if (ordered_mode)
                    begin
                        if (LW'(walk_reg) < lim)
                        begin
                            cell_raddr = walk_reg[AW-1:0];
                            state_next = S_ORD;
                        end
                        else
                        begin
                            res_next   = done_word;
                            state_next = S_RES;
                        end
                    end
                    else
                    begin
                        if (lim < LW'(2))
                        begin
                            res_next   = done_word;
                            state_next = S_RES;
                        end
                        else
                        begin
                            mark_raddr = '0;
                            j_next     = '0;
                            state_next = S_GRAY;
                        end
                    end
                end
            end

            S_INS:
            begin
                // cell_rdata holds entry j-1 when j is above the empty region
                cell_we = 1'b1;
                if ((CW'(j_reg) == empty_reg) || (members_reg && !(rd_key > key_reg)))
                begin
                    cell_wdata  = {pos_reg, key_reg};
                    loaded_next = CW'(pos_reg) + CW'(1);
                    empty_next  = empty_reg + CW'(!members_reg);
                    walk_next   = empty_reg + CW'(!members_reg);
                    state_next  = S_IDLE;
                end
                else
                begin
                    cell_wdata = cell_rdata;
                    j_next     = j_reg - AW'(1);
                end
            end

            S_ORD:
            begin
                res_next.category_index = CFG_W'(rd_cat);
                res_next.done_res       = 1'b0;
                walk_next               = walk_reg + CW'(1);
                state_next              = S_RES;
            end

            S_GRAY:
            begin
                if (mark_rdata == MARK_RIGHT)
                begin
                    mark_we                 = 1'b1;
                    mark_wdata              = MARK_LEFT;
                    res_next.category_index = CFG_W'(j_reg);
                    res_next.done_res       = 1'b0;
                    state_next              = S_RES;
                end
                else
                begin
                    // left flips back to right and the carry moves on
                    mark_we    = (mark_rdata == MARK_LEFT);
                    mark_wdata = MARK_RIGHT;
                    if (LW'(j_reg) + LW'(2) < lim)
                    begin
                        j_next = j_reg + AW'(1);
                    end
                    else
                    begin
                        res_next   = done_word;
                        state_next = S_RES;
                    end
                end
            end

            S_RES:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            loaded_reg  <= '0;
            empty_reg   <= '0;
            walk_reg    <= '0;
            j_reg       <= '0;
            pos_reg     <= '0;
            key_reg     <= '0;
            members_reg <= 1'b0;
            res_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            loaded_reg  <= loaded_next;
            empty_reg   <= empty_next;
            walk_reg    <= walk_next;
            j_reg       <= j_next;
            pos_reg     <= pos_next;
            key_reg     <= key_next;
            members_reg <= members_next;
            res_reg     <= res_next;
        end
    end

endmodule

>>> rtl/category_split_walker_unit.sv
// ----------------------------------------------------------------------------
// category_split_walker_unit
// walks two-group splits of categories, gray code or ordered by sort key
// ----------------------------------------------------------------------------
//
//  channel   signals                             beat
//  --------  ----------------------------------  ------------------------------
//  item      item_valid, item_stall, item        one load or one next request
//  result    result_valid, result_stall, result  one per next request
//  config    cfg_we, cfg_index, cfg_data         register write, no handshake
//
//  a load runs the insertion sort, shifting one entry per step down to its
//  slot, and a full table ignores it; the table ram gives one read and one
//  write a cycle
//  an ordered next reads one table entry, or reports done once the walk is
//  over; a gray code next scans the marks up to the last category but one,
//  one mark ram read a cycle, and reports done when no mark flips to left
//  item_stall is high while a beat is being worked on
//  the result register holds its beat while result_stall is high; the next
//  item is taken meanwhile, and a later result waits for the register
//  reset clears counters and registers; table and marks are valid once loaded
//
module category_split_walker_unit
    import csw_pkg::*;
#(
    parameter int MAX_CATEGORIES = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    // item channel
    input  logic             item_valid,
    output logic             item_stall,
    input  item_t            item,
    // result channel
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result,
    // configuration
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int AW     = $clog2(MAX_CATEGORIES);
    localparam int CELL_W = AW + KEY_W;

    // configuration registers
    logic [CFG_W-1:0] num_categories_reg;
    logic             ordered_mode_reg;

    // output register
    logic             result_valid_reg;
    result_t          result_reg;

    logic             busy;
    logic             start;
    logic             res_free;
    res_req_t         res;

    logic              cell_we;
    logic [AW-1:0]     cell_waddr;
    logic [CELL_W-1:0] cell_wdata;
    logic [AW-1:0]     cell_raddr;
    logic [CELL_W-1:0] cell_rdata;
    logic              mark_we;
    logic [AW-1:0]     mark_waddr;
    logic [1:0]        mark_wdata;
    logic [AW-1:0]     mark_raddr;
    logic [1:0]        mark_rdata;

    assign item_stall   = busy;
    assign start        = item_valid && !busy;
    assign res_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_categories_reg <= '0;
            ordered_mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_CATEGORIES: num_categories_reg <= cfg_data;
                REG_ORDERED_MODE:   ordered_mode_reg   <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // result beat leaves on a free cycle, new one loads when the sequencer offers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else if (res_free)
        begin
            result_valid_reg <= res.valid;
            if (res.valid)
            begin
                result_reg <= res.data;
            end
        end
    end

    // sorted table: category number and sort key per slot
    csw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAX_CATEGORIES)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    // gray code group marks, indexed by category
    csw_ram #(
        .WIDTH (2),
        .DEPTH (MAX_CATEGORIES)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    csw_seq #(
        .MAX_CATEGORIES (MAX_CATEGORIES)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .item           (item),
        .num_categories (num_categories_reg),
        .ordered_mode   (ordered_mode_reg),
        .res_free       (res_free),
        .busy           (busy),
        .res            (res),
        .cell_we        (cell_we),
        .cell_waddr     (cell_waddr),
        .cell_wdata     (cell_wdata),
        .cell_raddr     (cell_raddr),
        .cell_rdata     (cell_rdata),
        .mark_we        (mark_we),
        .mark_waddr     (mark_waddr),
        .mark_wdata     (mark_wdata),
        .mark_raddr     (mark_raddr),
        .mark_rdata     (mark_rdata)
    );

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for category_split_walker_unit
// builds category tables in gray code and ordered mode, asks for moves, and
// checks every reported move against a behavioral copy of the walk or a pinned
// move; items idle and results stall at random, with one long result hold-off
// ----------------------------------------------------------------------------
module tb;
    import csw_pkg::*;

    localparam int MAX_CAT       = 32;
    localparam int RAND_BEATS    = 1450;
    localparam int MAX_WAIT      = 17;
    localparam int HOLD_CYCLES   = 400;
    // leave room for two of the longest loads
    localparam int SETTLE_CYCLES = 2 * (MAX_CAT + 1) + 12;
    localparam int WATCHDOG_MAX  = 3000;

    typedef enum logic {ROW_REG, ROW_BEAT} row_kind_t;

    // one line of the directed table
    typedef struct {
        row_kind_t        kind;
        logic [IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0] reg_val;
        item_t            beat;
        bit               pinned;
        result_t          move;
    } dir_row_t;

    // travels with each offered beat; a pinned move replaces the prediction
    typedef struct {
        bit      pinned;
        result_t move;
    } move_note_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    item_t            item         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    result_t          result;
    logic             cfg_we       = 1'b0;
    logic [IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0] cfg_data     = '0;

    category_split_walker_unit #(
        .MAX_CATEGORIES(MAX_CAT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // walk model: sorted table, group marks and counters, plus register copy
    // ------------------------------------------------------------------------
    logic [5:0]         tbl_cat  [MAX_CAT];
    logic signed [31:0] tbl_key  [MAX_CAT];
    logic [1:0]         grp_mark [MAX_CAT];
    int                 fill_cnt  = 0;
    int                 empty_cnt = 0;
    int                 walk_pos  = 0;
    logic [CFG_W-1:0]   ncat_q    = '0;
    logic               ordered_q = 1'b0;

    move_note_t offered_notes  [$];
    result_t    expected_moves [$];
    dir_row_t   dir_rows       [$];

    // stimulus side view of the table fill, to keep walks on written entries
    int gen_fill = 0;
    int gen_hi   = 0;

    logic [31:0] key_pool [4];
    bit          snd_burst = 1'b0;
    bit          hold_req  = 1'b0;
    bit          hold_done = 1'b0;

    int fail_count    = 0;
    int live_beats    = 0;
    int loads_seen    = 0;
    int ignored_loads = 0;
    int requests_seen = 0;
    int moves_checked = 0;
    int done_moves    = 0;
    int phases        = 0;
    int reg_writes    = 0;

    task automatic predict_split_step(input item_t b, output bit has_move,
                                      output result_t mv);
        int         j;
        int         i;
        int         lim;
        bit         found;
        logic [5:0] cat;
        has_move = 1'b0;
        mv       = '0;
        found    = 1'b0;
        cat      = '0;
        if (b.operation == OP_LOAD)
        begin
            if (b.new_set)
            begin
                fill_cnt  = 0;
                empty_cnt = 0;
                walk_pos  = 0;
            end
            // a full table drops the load
            if (fill_cnt < MAX_CAT)
            begin
                grp_mark[fill_cnt] = b.has_members ? MARK_RIGHT : MARK_EMPTY;
                j = fill_cnt;
                if (!b.has_members)
                begin
                    // empty categories go to the tail of the empty block
                    for (j = fill_cnt; j > empty_cnt; j--)
                    begin
                        tbl_cat[j] = tbl_cat[j-1];
                        tbl_key[j] = tbl_key[j-1];
                    end
                    tbl_cat[empty_cnt] = 6'(fill_cnt);
                    empty_cnt++;
                end
                else
                begin
                    // stable: equal keys stay behind earlier ones
                    while (j > empty_cnt && $signed(tbl_key[j-1]) > $signed(b.sort_key))
                    begin
                        tbl_cat[j] = tbl_cat[j-1];
                        tbl_key[j] = tbl_key[j-1];
                        j--;
                    end
                    tbl_cat[j] = 6'(fill_cnt);
                    tbl_key[j] = b.sort_key;
                end
                fill_cnt++;
                walk_pos = empty_cnt;
            end
        end
        else
        begin
            lim = (ncat_q > MAX_CAT) ? MAX_CAT : int'(ncat_q);
            if (ordered_q)
            begin
                if (walk_pos < lim)
                begin
                    cat = tbl_cat[walk_pos];
                    walk_pos++;
                    found = 1'b1;
                end
            end
            else
            begin
                // binary counter over non-empty marks, last category excluded
                for (i = 0; i + 1 < lim && !found; i++)
                begin
                    if (grp_mark[i] == MARK_RIGHT)
                    begin
                        grp_mark[i] = MARK_LEFT;
                        cat = 6'(i);
                        found = 1'b1;
                    end
                    else if (grp_mark[i] == MARK_LEFT)
                    begin
                        grp_mark[i] = MARK_RIGHT;
                    end
                end
            end
            has_move          = 1'b1;
            mv.category_index = found ? cat : ncat_q;
            mv.done_res       = !found;
        end
    endtask

    // ------------------------------------------------------------------------
    // monitors: accepted item beats feed the model, result beats are checked
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : beat_monitor
        move_note_t note;
        bit         has_move;
        result_t    mv;
        if (rst_n && item_valid && !item_stall)
        begin
            note = offered_notes.pop_front();
            if (item.operation == OP_LOAD)
            begin
                loads_seen++;
                if (!item.new_set && fill_cnt >= MAX_CAT)
                    ignored_loads++;
            end
            else
            begin
                requests_seen++;
            end
            predict_split_step(item, has_move, mv);
            if (has_move)
                expected_moves.push_back(note.pinned ? note.move : mv);
        end
    end

    always @(posedge clk)
    begin : move_checker
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_moves.size() == 0)
            begin
                $error("unexpected move beat: category_index %0d done_res %0d",
                       result.category_index, result.done_res);
                fail_count++;
            end
            else
            begin
                want = expected_moves.pop_front();
                moves_checked++;
                if (want.done_res)
                    done_moves++;
                if (result.category_index !== want.category_index)
                begin
                    $error("category_index: expected %0d, got %0d",
                           want.category_index, result.category_index);
                    fail_count++;
                end
                if (result.done_res !== want.done_res)
                begin
                    $error("done_res: expected %0d, got %0d",
                           want.done_res, result.done_res);
                    fail_count++;
                end
            end
        end
    end

    // no beat on either channel for too long ends the run
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("** category_split_walker_unit: FAILED **");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // result side: random stall per beat, quiet stretches, one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int w;
        int streak;
        bit quiet;
        quiet  = 1'b0;
        streak = 0;
        @(posedge rst_n);
        forever
        begin
            if (streak == 0)
            begin
                quiet  = ($urandom_range(0, 3) == 0);
                streak = 50;
            end
            streak--;
            if (hold_req && !hold_done)
            begin
                // sender keeps offering meanwhile, so the block backs up
                hold_done = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    result_stall <= 1'b1;
                end
            end
            else
            begin
                w = quiet ? 0 : $urandom_range(0, MAX_WAIT);
                repeat (w)
                begin
                    @(negedge clk);
                    result_stall <= 1'b1;
                end
            end
            @(negedge clk);
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(result_valid && !result_stall));
        end
    end

    // ------------------------------------------------------------------------
    // item side helpers
    // ------------------------------------------------------------------------
    task automatic send_beat(input item_t b, input bit pinned, input result_t mv);
        int         gap;
        move_note_t note;
        gap         = snd_burst ? 0 : $urandom_range(0, MAX_WAIT);
        note.pinned = pinned;
        note.move   = mv;
        if (b.operation == OP_LOAD)
        begin
            if (b.new_set)
                gen_fill = 0;
            // loads into a full table are not counted
            if (gen_fill < MAX_CAT)
            begin
                gen_fill++;
                live_beats++;
            end
            if (gen_fill > gen_hi)
                gen_hi = gen_fill;
        end
        else
        begin
            live_beats++;
        end
        repeat (gap)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        offered_notes.push_back(note);
        item_valid <= 1'b1;
        item       <= b;
        do
            @(posedge clk);
        while (!(item_valid && !item_stall));
    endtask

    // wait for every move, then let a trailing load finish
    task automatic drain_all();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_moves.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == REG_NUM_CATEGORIES)
            ncat_q = val;
        else
            ordered_q = val[0];
        reg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void add_reg(input logic [IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
        dir_row_t r;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        r.beat    = '0;
        r.pinned  = 1'b0;
        r.move    = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_beat(input logic op, input logic ns, input logic mem,
                                     input logic [KEY_W-1:0] key, input bit pinned,
                                     input logic [CFG_W-1:0] idx, input logic done);
        dir_row_t r;
        r.kind                = ROW_BEAT;
        r.reg_idx             = '0;
        r.reg_val             = '0;
        r.beat.operation      = op;
        r.beat.new_set        = ns;
        r.beat.has_members    = mem;
        r.beat.sort_key       = key;
        r.pinned              = pinned;
        r.move.category_index = idx;
        r.move.done_res       = done;
        dir_rows.push_back(r);
    endfunction

    // extremes, repeats from a small pool for stable-sort ties, and noise
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return key_pool[$urandom_range(0, 3)];
            5:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        item_t      b;
        int         set_len;
        int         cap;
        int         n_req;
        int         k;
        int         dens;
        int         rand_start;
        bit         hold_phase;
        logic [5:0] ncat;
        foreach (tbl_cat[i])
        begin
            tbl_cat[i]  = '0;
            tbl_key[i]  = '0;
            grp_mark[i] = MARK_EMPTY;
        end
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;

        // reset config: zero categories, gray walk, so done at once
        add_beat(OP_NEXT, 1'b0, 1'b0, 32'h0, 1'b1, 6'd0, 1'b1);
        add_reg(REG_ORDERED_MODE, 6'd1);
        add_beat(OP_NEXT, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 6'd0, 1'b1);
        // four categories: max key, empty, min key, min key again
        add_reg(REG_NUM_CATEGORIES, 6'd4);
        add_reg(REG_ORDERED_MODE, 6'd0);
        add_beat(OP_LOAD, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0, 6'd0, 1'b0);
        add_beat(OP_LOAD, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 6'd0, 1'b0);
        add_beat(OP_LOAD, 1'b0, 1'b1, 32'h8000_0000, 1'b0, 6'd0, 1'b0);
        add_beat(OP_LOAD, 1'b0, 1'b1, 32'h8000_0000, 1'b0, 6'd0, 1'b0);
        // gray walk skips the empty one and never flips the last
        add_beat(OP_NEXT, 1'b0, 1'b0, 32'h0, 1'b1, 6'd0, 1'b0);
        add_beat(OP_NEXT, 1'b0, 1'b0, 32'h0, 1'b1, 6'd2, 1'b0);
        add_beat(OP_NEXT, 1'b0, 1'b0, 32'h0, 1'b1, 6'd0, 1'b0);
        add_beat(OP_NEXT, 1'b0, 1'b0, 32'h0, 1'b1, 6'd4, 1'b1);
        add_beat(OP_NEXT, 1'b1, 1'b1, 32'h5555_AAAA, 1'b0, 6'd0, 1'b0);
        // same table walked by key, ties in load order, then past the end
        add_reg(REG_ORDERED_MODE, 6'd1);
        add_beat(OP_NEXT, 1'b0, 1'b0, 32'h0, 1'b0, 6'd0, 1'b0);
        add_beat(OP_NEXT, 1'b0, 1'b0, 32'h0, 1'b0, 6'd0, 1'b0);
        add_beat(OP_NEXT, 1'b0, 1'b0, 32'h0, 1'b0, 6'd0, 1'b0);
        add_beat(OP_NEXT, 1'b0, 1'b0, 32'h0, 1'b1, 6'd4, 1'b1);
        add_beat(OP_NEXT, 1'b0, 1'b0, 32'h0, 1'b1, 6'd4, 1'b1);
        // a single category never moves in the gray walk
        add_reg(REG_NUM_CATEGORIES, 6'd1);
        add_reg(REG_ORDERED_MODE, 6'd0);
        add_beat(OP_LOAD, 1'b1, 1'b1, 32'h0001_2345, 1'b0, 6'd0, 1'b0);
        add_beat(OP_NEXT, 1'b0, 1'b0, 32'h0, 1'b1, 6'd1, 1'b1);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_REG)
            begin
                drain_all();
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
            end
            else
            begin
                send_beat(dir_rows[r].beat, dir_rows[r].pinned, dir_rows[r].move);
            end
        end

        // random phases: program at idle, load a set, then mostly walk it
        rand_start = live_beats;
        while (live_beats - rand_start < RAND_BEATS)
        begin
            case ($urandom_range(0, 9))
                0:       set_len = $urandom_range(30, MAX_CAT + 2);
                1, 2:    set_len = $urandom_range(11, 24);
                default: set_len = $urandom_range(0, 10);
            endcase
            // the walk may only reach entries written since reset
            cap = (set_len > MAX_CAT) ? MAX_CAT : set_len;
            if (gen_hi > cap)
                cap = gen_hi;
            if (cap == MAX_CAT && $urandom_range(0, 3) == 0)
                ncat = 6'($urandom_range(MAX_CAT, 63));
            else if ($urandom_range(0, 1) == 1)
                ncat = 6'(cap);
            else
                ncat = 6'($urandom_range(0, cap));
            hold_phase = !hold_req && (live_beats - rand_start >= RAND_BEATS / 2);
            foreach (key_pool[i])
                key_pool[i] = $urandom;
            dens = $urandom_range(0, 4);

            drain_all();
            write_reg(REG_NUM_CATEGORIES, ncat);
            write_reg(REG_ORDERED_MODE, {5'($urandom_range(0, 31)), 1'($urandom_range(0, 1))});
            snd_burst = hold_phase || ($urandom_range(0, 3) == 0);
            if (hold_phase)
                hold_req = 1'b1;
            phases++;

            for (k = 0; k < set_len; k++)
            begin
                b.operation   = OP_LOAD;
                b.new_set     = (k == 0);
                b.has_members = ($urandom_range(0, 99) < dens * 25);
                b.sort_key    = pick_key();
                send_beat(b, 1'b0, '0);
            end

            n_req = hold_phase ? 60 : $urandom_range(1, 40);
            for (k = 0; k < n_req; k++)
            begin
                b.sort_key    = pick_key();
                b.has_members = 1'($urandom_range(0, 1));
                b.new_set     = 1'($urandom_range(0, 1));
                b.operation   = OP_NEXT;
                // now and then an appended load, rarely a fresh set, mid-walk
                if ($urandom_range(0, 9) == 0)
                begin
                    b.operation = OP_LOAD;
                    b.new_set   = ($urandom_range(0, 7) == 0);
                end
                send_beat(b, 1'b0, '0);
            end
        end

        drain_all();
        $display("run: %0d loads (%0d dropped on a full table), %0d move requests, %0d phases",
                 loads_seen, ignored_loads, requests_seen, phases);
        $display("run: %0d moves checked, %0d of them done, %0d register writes",
                 moves_checked, done_moves, reg_writes);
        if (fail_count == 0)
        begin
            $display("** category_split_walker_unit: PASSED **");
        end
        else
        begin
            $display("** category_split_walker_unit: FAILED **");
        end
        $finish;
    end

endmodule
